// ----- hw/rtl/lcps_pkg.sv -----
package lcps_pkg;

    localparam int unsigned TimeWidth  = 32;
    localparam int unsigned KindWidth  = 3;
    localparam int unsigned IndexWidth = 3;
    localparam int unsigned DurWidth   = 9;
    localparam int unsigned ColorWidth = 8;

    localparam logic [KindWidth-1:0] KIND_NONE      = 3'd0;
    localparam logic [KindWidth-1:0] KIND_ENABLED   = 3'd1;
    localparam logic [KindWidth-1:0] KIND_DISABLED  = 3'd2;
    localparam logic [KindWidth-1:0] KIND_MOTOR_ON  = 3'd3;
    localparam logic [KindWidth-1:0] KIND_MOTOR_OFF = 3'd4;

    localparam logic OP_START  = 1'b0;
    localparam logic OP_RENDER = 1'b1;

    typedef struct packed {
        logic [ColorWidth-1:0] blue;
        logic [ColorWidth-1:0] green;
        logic [ColorWidth-1:0] red;
    } rgb_t;

    function automatic logic is_single(input logic [KindWidth-1:0] kind);
        return (kind == KIND_ENABLED) || (kind == KIND_MOTOR_ON) || (kind == KIND_MOTOR_OFF);
    endfunction

    function automatic logic [IndexWidth-1:0] phase_count(input logic [KindWidth-1:0] kind);
        logic [IndexWidth-1:0] cnt;
        cnt = 3'd0;
        if (kind == KIND_DISABLED) begin
            cnt = 3'd5;
        end else if (is_single(kind)) begin
            cnt = 3'd3;
        end
        return cnt;
    endfunction

    function automatic logic [DurWidth-1:0] phase_dur(input logic [KindWidth-1:0]  kind,
                                                      input logic [IndexWidth-1:0] idx);
        logic [DurWidth-1:0] dur;
        dur = 9'd0;
        if (kind == KIND_DISABLED) begin
            unique case (idx)
                3'd0:    dur = 9'd60;
                3'd1:    dur = 9'd180;
                3'd2:    dur = 9'd140;
                3'd3:    dur = 9'd180;
                3'd4:    dur = 9'd120;
                default: dur = 9'd0;
            endcase
        end else begin
            unique case (idx)
                3'd0:    dur = 9'd60;
                3'd1:    dur = 9'd300;
                3'd2:    dur = 9'd120;
                default: dur = 9'd0;
            endcase
        end
        return dur;
    endfunction

    function automatic logic phase_lit(input logic [KindWidth-1:0]  kind,
                                       input logic [IndexWidth-1:0] idx);
        logic lit;
        lit = 1'b0;
        if (kind == KIND_DISABLED) begin
            lit = (idx == 3'd1) || (idx == 3'd3);
        end else begin
            lit = (idx == 3'd1);
        end
        return lit;
    endfunction

    function automatic rgb_t kind_color(input logic [KindWidth-1:0] kind);
        rgb_t c;
        c = '0;
        unique case (kind)
            KIND_ENABLED:   c = '{blue: 8'd0,   green: 8'd255, red: 8'd0};
            KIND_DISABLED:  c = '{blue: 8'd0,   green: 8'd0,   red: 8'd255};
            KIND_MOTOR_ON:  c = '{blue: 8'd255, green: 8'd0,   red: 8'd128};
            KIND_MOTOR_OFF: c = '{blue: 8'd0,   green: 8'd160, red: 8'd255};
            default:        c = '0;
        endcase
        return c;
    endfunction

endpackage

// ----- hw/rtl/lcps_sub_unit.sv -----
module lcps_sub_unit (
    input  logic [lcps_pkg::TimeWidth-1:0] a,
    input  logic [lcps_pkg::TimeWidth-1:0] b,
    output logic [lcps_pkg::TimeWidth-1:0] diff,
    output logic                           a_ge_b
);

    logic [lcps_pkg::TimeWidth:0] wide;

    assign wide   = {1'b0, a} - {1'b0, b};
    assign diff   = wide[lcps_pkg::TimeWidth-1:0];
    assign a_ge_b = ~wide[lcps_pkg::TimeWidth];

endmodule

// ----- hw/rtl/led_cue_phase_sequencer.sv -----
// One cue slot that plays fixed flash patterns. A start item (tuser 0) is taken in the idle
// state and the block is ready again on the next cycle. A render item (tuser 1) goes straight
// to the result when no cue runs, and otherwise passes through the elapsed, step and fix
// states, as one shared 32-bit subtractor first forms the elapsed time, then tests and removes
// one phase duration per cycle, and finally rebuilds the phase start time. Each render item
// gives exactly one result item; the block takes no new item while a render is in progress.
module led_cue_phase_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // cue_kind [2:0], now_ms [34:3], zero [39:35]
    input  logic        s_tuser,   // op [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // red_level [7:0], green_level [15:8], blue_level [23:16]
    output logic        m_tuser    // showing [0]
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ELAPSED,
        ST_STEP,
        ST_FIX,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    logic [lcps_pkg::KindWidth-1:0]  active_kind_reg, active_kind_next;
    logic [lcps_pkg::IndexWidth-1:0] phase_index_reg, phase_index_next;
    logic [lcps_pkg::TimeWidth-1:0]  phase_start_reg, phase_start_next;
    logic                            cue_running_reg, cue_running_next;
    logic [lcps_pkg::TimeWidth-1:0]  now_reg, now_next;
    logic [lcps_pkg::TimeWidth-1:0]  elapsed_reg, elapsed_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic                            showing_reg, showing_next;
    lcps_pkg::rgb_t                  color_reg, color_next;

    logic [lcps_pkg::KindWidth-1:0]  in_kind;
    logic [lcps_pkg::TimeWidth-1:0]  in_now;
    logic                            in_accept;
    logic [lcps_pkg::TimeWidth-1:0]  sub_a, sub_b, sub_diff;
    logic                            sub_ge;
    logic [lcps_pkg::IndexWidth-1:0] count;
    logic                            out_free;

    assign in_kind   = s_tdata[2:0];
    assign in_now    = s_tdata[34:3];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign count     = lcps_pkg::phase_count(active_kind_reg);
    assign out_free  = !m_tvalid_reg || m_tready;

    always_comb begin
        unique case (state_reg)
            ST_STEP: begin
                sub_a = elapsed_reg;
                sub_b = {{(lcps_pkg::TimeWidth-lcps_pkg::DurWidth){1'b0}},
                         lcps_pkg::phase_dur(active_kind_reg, phase_index_reg)};
            end
            ST_FIX: begin
                sub_a = now_reg;
                sub_b = elapsed_reg;
            end
            default: begin
                sub_a = now_reg;
                sub_b = phase_start_reg;
            end
        endcase
    end

    lcps_sub_unit u_sub (
        .a      (sub_a),
        .b      (sub_b),
        .diff   (sub_diff),
        .a_ge_b (sub_ge)
    );

    always_comb begin
        state_next       = state_reg;
        active_kind_next = active_kind_reg;
        phase_index_next = phase_index_reg;
        phase_start_next = phase_start_reg;
        cue_running_next = cue_running_reg;
        now_next         = now_reg;
        elapsed_next     = elapsed_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        showing_next     = showing_reg;
        color_next       = color_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    now_next = in_now;
                    if (s_tuser == lcps_pkg::OP_START) begin
                        if (in_kind == lcps_pkg::KIND_NONE ||
                            in_kind > lcps_pkg::KIND_MOTOR_OFF) begin
                            cue_running_next = 1'b0;
                        end else begin
                            active_kind_next = in_kind;
                            phase_index_next = '0;
                            phase_start_next = in_now;
                            cue_running_next = 1'b1;
                        end
                    end else if (cue_running_reg) begin
                        state_next = ST_ELAPSED;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_ELAPSED: begin
                elapsed_next = sub_diff;
                state_next   = ST_STEP;
            end
            ST_STEP: begin
                if (phase_index_reg < count && sub_ge) begin
                    elapsed_next     = sub_diff;
                    phase_index_next = phase_index_reg + 3'd1;
                end else begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX: begin
                phase_start_next = sub_diff;
                if (phase_index_reg >= count) begin
                    cue_running_next = 1'b0;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    showing_next  = cue_running_reg;
                    if (cue_running_reg &&
                        lcps_pkg::phase_lit(active_kind_reg, phase_index_reg)) begin
                        color_next = lcps_pkg::kind_color(active_kind_reg);
                    end else begin
                        color_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            active_kind_reg <= lcps_pkg::KIND_NONE;
            phase_index_reg <= '0;
            phase_start_reg <= '0;
            cue_running_reg <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            active_kind_reg <= active_kind_next;
            phase_index_reg <= phase_index_next;
            phase_start_reg <= phase_start_next;
            cue_running_reg <= cue_running_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
        now_reg     <= now_next;
        elapsed_reg <= elapsed_next;
        showing_reg <= showing_next;
        color_reg   <= color_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = showing_reg;
    assign m_tdata  = color_reg;

    a_dark_when_not_showing: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == 24'd0)
        else $error("result without a cue carries a color");

    a_running_kind_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cue_running_reg |-> active_kind_reg != lcps_pkg::KIND_NONE &&
                            active_kind_reg <= lcps_pkg::KIND_MOTOR_OFF)
        else $error("running cue has no pattern");

    a_idle_phase_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE && cue_running_reg |-> phase_index_reg < count)
        else $error("running cue rests past its last phase");

    a_start_rewinds: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && s_tuser == lcps_pkg::OP_START && in_kind != lcps_pkg::KIND_NONE &&
        in_kind <= lcps_pkg::KIND_MOTOR_OFF
        |=> cue_running_reg && phase_index_reg == '0 && phase_start_reg == $past(in_now))
        else $error("start item did not rewind the cue");

    a_render_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DONE && out_free |=> m_tvalid && state_reg == ST_IDLE)
        else $error("render item finished without a result");

endmodule
